### hdl/iirdf2_pkg.sv
package iirdf2_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int W_W      = 32;
	localparam int FRAC     = 14;
	localparam int DEPTH    = 3;
	localparam int ORDER    = 3;
	localparam int PROD_W   = COEF_W + W_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int SH_W     = ACC_W - FRAC;
	localparam int K_W      = $clog2(DEPTH);
	localparam int NUM_IW   = $clog2(DEPTH + 1);
	localparam int CFG_IW   = 3;

	localparam logic [CFG_IW-1:0] REG_NUM_COEF_0 = 3'd0;
	localparam logic [CFG_IW-1:0] REG_NUM_COEF_1 = 3'd1;
	localparam logic [CFG_IW-1:0] REG_NUM_COEF_2 = 3'd2;
	localparam logic [CFG_IW-1:0] REG_NUM_COEF_3 = 3'd3;
	localparam logic [CFG_IW-1:0] REG_DEN_COEF_1 = 3'd4;
	localparam logic [CFG_IW-1:0] REG_DEN_COEF_2 = 3'd5;
	localparam logic [CFG_IW-1:0] REG_DEN_COEF_3 = 3'd6;

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC);

	typedef struct packed {
		logic init;
		logic issue;
		logic sub;
	} mac_ctl_t;

endpackage

### hdl/iirdf2_mac.sv
module iirdf2_mac (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  iirdf2_pkg::mac_ctl_t                         ctl,
	input  logic signed [iirdf2_pkg::ACC_W-1:0]          init_val,
	input  logic signed [iirdf2_pkg::COEF_W-1:0]         op_coef,
	input  logic signed [iirdf2_pkg::W_W-1:0]            op_data,
	output logic signed [iirdf2_pkg::ACC_W-1:0]          acc
);

	logic signed [iirdf2_pkg::PROD_W-1:0] prod_s1;
	logic                                 pend_q;
	logic                                 sub_q;
	logic signed [iirdf2_pkg::ACC_W-1:0]  acc_q;
	logic signed [iirdf2_pkg::ACC_W-1:0]  prod_ext;

	assign prod_ext = iirdf2_pkg::ACC_W'(prod_s1);
	assign acc      = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= iirdf2_pkg::PROD_W'(op_coef) * iirdf2_pkg::PROD_W'(op_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			sub_q  <= 1'b0;
		end else begin
			pend_q <= ctl.issue;
			if (ctl.issue) begin
				sub_q <= ctl.sub;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			acc_q <= init_val;
		end else if (pend_q) begin
			acc_q <= sub_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
		end
	end

endmodule

### hdl/iir_direct_form_two_filter.sv
// Third-order direct form II IIR filter for signed 16-bit samples with Q3.14 coefficients.
// One shared 18 x 32 bit multiply-accumulate unit forms the feedback sum and then the output
// sum: each sum issues one multiply per tap and is followed by a drain state, the node value is
// rounded and saturated in the S_W state, and the output is rounded into the output register
// in the commit state S_Y. The next sample can be accepted once the result is in the output
// register. The input is not ready while a sample is in progress, and a finished sample
// waits in the output register until it is taken. Coefficients are written through the
// configuration port; the user must write them only while the filter is idle, which the block
// itself does not enforce. A restart bit on a sample clears the delay line first. Both the
// internal node and the output saturate, and clipped reports either.
module iir_direct_form_two_filter (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_wr_en,
	input  logic [iirdf2_pkg::CFG_IW-1:0]             cfg_index,
	input  logic [iirdf2_pkg::COEF_W-1:0]             cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [iirdf2_pkg::SAMPLE_W-1:0]    sample_in,
	input  logic                                      restart,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [iirdf2_pkg::SAMPLE_W-1:0]    sample_out,
	output logic                                      clipped
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_FB       = 3'd1;
	localparam logic [2:0] S_FB_DRAIN = 3'd2;
	localparam logic [2:0] S_W        = 3'd3;
	localparam logic [2:0] S_FF0      = 3'd4;
	localparam logic [2:0] S_FF       = 3'd5;
	localparam logic [2:0] S_FF_DRAIN = 3'd6;
	localparam logic [2:0] S_Y        = 3'd7;

	localparam logic [iirdf2_pkg::K_W-1:0] K_LAST = iirdf2_pkg::K_W'(iirdf2_pkg::ORDER - 1);

	logic [2:0]                                  state_q;
	logic [iirdf2_pkg::K_W-1:0]                  k_q;
	logic signed [iirdf2_pkg::COEF_W-1:0]        num_coef_q [iirdf2_pkg::DEPTH+1];
	logic signed [iirdf2_pkg::COEF_W-1:0]        den_coef_q [iirdf2_pkg::DEPTH];
	logic signed [iirdf2_pkg::W_W-1:0]           dl_q [iirdf2_pkg::DEPTH];
	logic signed [iirdf2_pkg::W_W-1:0]           w_q;
	logic                                        clip_q;
	logic                                        out_valid_q;
	logic signed [iirdf2_pkg::SAMPLE_W-1:0]      sample_out_q;
	logic                                        clipped_q;

	iirdf2_pkg::mac_ctl_t                        mac_ctl;
	logic signed [iirdf2_pkg::ACC_W-1:0]         init_val;
	logic signed [iirdf2_pkg::COEF_W-1:0]        op_coef;
	logic signed [iirdf2_pkg::W_W-1:0]           op_data;
	logic signed [iirdf2_pkg::ACC_W-1:0]         acc;
	logic signed [iirdf2_pkg::ACC_W-1:0]         acc_rnd;
	logic signed [iirdf2_pkg::SH_W-1:0]          acc_sh;
	logic signed [iirdf2_pkg::W_W-1:0]           w_sat;
	logic                                        w_ovf;
	logic signed [iirdf2_pkg::SAMPLE_W-1:0]      y_sat;
	logic                                        y_ovf;
	logic                                        accept;
	logic                                        commit;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign commit     = (state_q == S_Y) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	// Round half up and drop the fraction, then saturate to the node and sample widths.
	assign acc_rnd = acc + iirdf2_pkg::ACC_W'(1 << (iirdf2_pkg::FRAC - 1));
	assign acc_sh  = acc_rnd[iirdf2_pkg::ACC_W-1:iirdf2_pkg::FRAC];
	assign w_ovf   = !((&acc_sh[iirdf2_pkg::SH_W-1:iirdf2_pkg::W_W-1])
		|| !(|acc_sh[iirdf2_pkg::SH_W-1:iirdf2_pkg::W_W-1]));
	assign y_ovf   = !((&acc_sh[iirdf2_pkg::SH_W-1:iirdf2_pkg::SAMPLE_W-1])
		|| !(|acc_sh[iirdf2_pkg::SH_W-1:iirdf2_pkg::SAMPLE_W-1]));

	always_comb begin
		if (w_ovf) begin
			w_sat = {acc_sh[iirdf2_pkg::SH_W-1], {(iirdf2_pkg::W_W-1){!acc_sh[iirdf2_pkg::SH_W-1]}}};
		end else begin
			w_sat = acc_sh[iirdf2_pkg::W_W-1:0];
		end
		if (y_ovf) begin
			y_sat = {acc_sh[iirdf2_pkg::SH_W-1],
				{(iirdf2_pkg::SAMPLE_W-1){!acc_sh[iirdf2_pkg::SH_W-1]}}};
		end else begin
			y_sat = acc_sh[iirdf2_pkg::SAMPLE_W-1:0];
		end
	end

	always_comb begin
		mac_ctl  = '0;
		init_val = '0;
		op_coef  = den_coef_q[k_q];
		op_data  = dl_q[k_q];
		unique case (state_q)
			S_IDLE: begin
				mac_ctl.init = accept;
				init_val = {{(iirdf2_pkg::ACC_W - iirdf2_pkg::SAMPLE_W - iirdf2_pkg::FRAC)
					{sample_in[iirdf2_pkg::SAMPLE_W-1]}}, sample_in, iirdf2_pkg::FRAC'(0)};
			end
			S_FB: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.sub   = 1'b1;
			end
			S_W: begin
				mac_ctl.init = 1'b1;
			end
			S_FF0: begin
				mac_ctl.issue = 1'b1;
				op_coef = num_coef_q[0];
				op_data = w_q;
			end
			S_FF: begin
				mac_ctl.issue = 1'b1;
				op_coef = num_coef_q[iirdf2_pkg::NUM_IW'(k_q) + iirdf2_pkg::NUM_IW'(1)];
			end
			S_FB_DRAIN, S_FF_DRAIN, S_Y: begin
			end
			default: begin
			end
		endcase
	end

	iirdf2_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.init_val (init_val),
		.op_coef  (op_coef),
		.op_data  (op_data),
		.acc      (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (accept) begin
						state_q <= S_FB;
					end
				end
				S_FB: begin
					if (k_q == K_LAST) begin
						state_q <= S_FB_DRAIN;
						k_q     <= '0;
					end else begin
						k_q <= k_q + iirdf2_pkg::K_W'(1);
					end
				end
				S_FB_DRAIN: state_q <= S_W;
				S_W:        state_q <= S_FF0;
				S_FF0:      state_q <= S_FF;
				S_FF: begin
					if (k_q == K_LAST) begin
						state_q <= S_FF_DRAIN;
						k_q     <= '0;
					end else begin
						k_q <= k_q + iirdf2_pkg::K_W'(1);
					end
				end
				S_FF_DRAIN: state_q <= S_Y;
				S_Y: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_coef_q[0] <= iirdf2_pkg::COEF_ONE;
			for (int i = 1; i <= iirdf2_pkg::DEPTH; i++) begin
				num_coef_q[i] <= '0;
			end
			for (int i = 0; i < iirdf2_pkg::DEPTH; i++) begin
				den_coef_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				iirdf2_pkg::REG_NUM_COEF_0: num_coef_q[0] <= cfg_data;
				iirdf2_pkg::REG_NUM_COEF_1: num_coef_q[1] <= cfg_data;
				iirdf2_pkg::REG_NUM_COEF_2: num_coef_q[2] <= cfg_data;
				iirdf2_pkg::REG_NUM_COEF_3: num_coef_q[3] <= cfg_data;
				iirdf2_pkg::REG_DEN_COEF_1: den_coef_q[0] <= cfg_data;
				iirdf2_pkg::REG_DEN_COEF_2: den_coef_q[1] <= cfg_data;
				iirdf2_pkg::REG_DEN_COEF_3: den_coef_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iirdf2_pkg::DEPTH; i++) begin
				dl_q[i] <= '0;
			end
		end else if (accept && restart) begin
			for (int i = 0; i < iirdf2_pkg::DEPTH; i++) begin
				dl_q[i] <= '0;
			end
		end else if (commit) begin
			for (int i = iirdf2_pkg::DEPTH - 1; i > 0; i--) begin
				dl_q[i] <= dl_q[i-1];
			end
			dl_q[0] <= w_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_W) begin
			w_q    <= w_sat;
			clip_q <= w_ovf;
		end
		if (commit) begin
			sample_out_q <= y_sat;
			clipped_q    <= clip_q || y_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// A sample starts the feedback taps on the cycle after its input transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_FB) && !in_ready)
		else $error("sample did not start the feedback sum");

	// A new output only appears from the commit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_Y))
		else $error("output raised outside the commit step");

	// The accumulator is only reloaded while no product is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W) |-> $past(state_q) == S_FB_DRAIN)
		else $error("rounding step reached without draining the feedback sum");

endmodule
